[hw/rtl/rgbs_pkg.sv]
// Shared types, constants and defaults of the RGB 3x3 sharpen block.
package rgbs_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_OUT_W = 10;
  localparam int ROW_OUT_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 12;

  localparam int MAX_LINE_PIXELS_DEF = 1024;
  localparam int MAX_ROWS_DEF        = 4095;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd500;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 12'd281;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int NUM_CH  = 3;
  localparam int WIN_N   = 9;
  localparam int WIN_CTR = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // channel 2 red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;

  // one pixel's worth of results, before compaction
  typedef struct packed {
    logic                 e_center;   // (c-1,r-1)
    logic                 e_rowend;   // (W-1,r-1)
    logic                 e_lastrow;  // (c,r) unchanged
    logic                 interior;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    pixel_t               sharp;
    pixel_t               pass_center;
    pixel_t               pass_rowend;
    pixel_t               pass_lastrow;
  } bundle_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    pixel_t               px;
    logic                 last;
  } result_t;

endpackage

[hw/rtl/rgbs_pix_if.sv]
// Input pixel channel.
interface rgbs_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rgbs_pkg::PIX_W-1:0] red_in;
  logic [rgbs_pkg::PIX_W-1:0] green_in;
  logic [rgbs_pkg::PIX_W-1:0] blue_in;

  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

[hw/rtl/rgbs_res_if.sv]
// Result channel.
interface rgbs_res_if;
  logic                           valid;
  logic                           ready;
  logic [rgbs_pkg::COL_OUT_W-1:0] col_out;
  logic [rgbs_pkg::ROW_OUT_W-1:0] row_out;
  logic [rgbs_pkg::PIX_W-1:0]     red_out;
  logic [rgbs_pkg::PIX_W-1:0]     green_out;
  logic [rgbs_pkg::PIX_W-1:0]     blue_out;
  logic                           last_of_run;

  modport source(output valid, col_out, row_out, red_out, green_out, blue_out,
                 last_of_run, input ready);
  modport sink(input valid, col_out, row_out, red_out, green_out, blue_out,
               last_of_run, output ready);
endinterface

[hw/rtl/rgbs_cfg_if.sv]
// Configuration write channel.
interface rgbs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rgbs_pkg::CFG_IDX_W-1:0] index;
  logic [rgbs_pkg::CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/rgbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rgbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rgbs_lane.sv]
// One channel lane: 9*center minus eight neighbors, clamped to 0..255.
module rgbs_lane (
  input  logic [rgbs_pkg::WIN_N-1:0][rgbs_pkg::PIX_W-1:0] win,
  output logic [rgbs_pkg::PIX_W-1:0]                      sharp
);

  localparam int SUM_W = rgbs_pkg::PIX_W + 3;  // eight neighbors
  localparam int ACC_W = rgbs_pkg::PIX_W + 5;  // signed 9*c - sum

  logic [SUM_W-1:0]        nb_sum;
  logic [SUM_W:0]          ctr9;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    nb_sum = '0;
    for (int i = 0; i < rgbs_pkg::WIN_N; i++) begin
      if (i != rgbs_pkg::WIN_CTR) begin
        nb_sum = nb_sum + SUM_W'(win[i]);
      end
    end
  end

  assign ctr9 = {(SUM_W+1-rgbs_pkg::PIX_W-3)'(0), win[rgbs_pkg::WIN_CTR], 3'b000}
              + (SUM_W+1)'(win[rgbs_pkg::WIN_CTR]);
  assign acc  = signed'({1'b0, ctr9}) - signed'({2'b00, nb_sum});

  always_comb begin
    if (acc < 0) begin
      sharp = '0;
    end else if (acc > signed'(ACC_W'(255))) begin
      sharp = '1;
    end else begin
      sharp = acc[rgbs_pkg::PIX_W-1:0];
    end
  end

endmodule

[hw/rtl/rgbs_merge.sv]
// Merge stage: packs the lanes' and pass-through values into results and queues them.
module rgbs_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bnd_valid,
  input  rgbs_pkg::bundle_t bnd,
  output logic              bnd_ready,
  rgbs_res_if.source        out_if
);

  localparam int AW = rgbs_pkg::FIFO_AW;
  localparam int CW = rgbs_pkg::FIFO_CW;

  rgbs_pkg::result_t cand [3];
  logic              cand_en [3];
  rgbs_pkg::result_t slot [3];
  logic [1:0]        n_res;
  logic              push;
  logic              pop;

  rgbs_pkg::result_t mem [rgbs_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r, cnt_nxt, free;

  always_comb begin
    cand_en[0] = bnd.e_center;
    cand_en[1] = bnd.e_rowend;
    cand_en[2] = bnd.e_lastrow;

    cand[0].col  = bnd.col - rgbs_pkg::COL_OUT_W'(1);
    cand[0].row  = bnd.row - rgbs_pkg::ROW_OUT_W'(1);
    cand[0].px   = bnd.interior ? bnd.sharp : bnd.pass_center;
    cand[0].last = !bnd.e_rowend && !bnd.e_lastrow;

    cand[1].col  = bnd.col;
    cand[1].row  = bnd.row - rgbs_pkg::ROW_OUT_W'(1);
    cand[1].px   = bnd.pass_rowend;
    cand[1].last = !bnd.e_lastrow;

    cand[2].col  = bnd.col;
    cand[2].row  = bnd.row;
    cand[2].px   = bnd.pass_lastrow;
    cand[2].last = 1'b1;

    // compact the enabled candidates in order
    n_res = '0;
    for (int k = 0; k < 3; k++) begin
      slot[k] = cand[2];
    end
    for (int k = 0; k < 3; k++) begin
      if (cand_en[k]) begin
        slot[n_res] = cand[k];
        n_res       = n_res + 2'd1;
      end
    end
  end

  assign free      = CW'(rgbs_pkg::FIFO_DEPTH) - cnt_r;
  assign bnd_ready = free >= CW'(n_res);
  assign push      = bnd_valid && bnd_ready;
  assign pop       = out_if.valid && out_if.ready;
  assign cnt_nxt   = cnt_r + (push ? CW'(n_res) : CW'(0)) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + AW'(n_res);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (push && (k < int'(n_res))) begin
        mem[wp_r + AW'(k)] <= slot[k];
      end
    end
  end

  assign out_if.valid       = cnt_r != '0;
  assign out_if.col_out     = mem[rp_r].col;
  assign out_if.row_out     = mem[rp_r].row;
  assign out_if.red_out     = mem[rp_r].px[2];
  assign out_if.green_out   = mem[rp_r].px[1];
  assign out_if.blue_out    = mem[rp_r].px[0];
  assign out_if.last_of_run = mem[rp_r].last;

endmodule

[hw/rtl/rgb_sharpen_3x3.sv]
// Top level of the streaming RGB 3x3 sharpen block.
//
// Pixels enter in raster order, one item per clock while the result queue has
// room, and each interior pixel leaves as 9*center minus its eight neighbors
// per channel, clamped to 0..255; pixels of the first and last row and column
// pass through unchanged. Each result carries its column and row, and
// last_of_run marks the final result caused by one input item. An input at
// (c,r) finishes the neighborhood of (c-1,r-1); the row-end pixel and, on the
// last row, the input itself follow it, so one item yields zero to three
// results. The output side delivers one result per cycle while out_if.ready
// is high, so the last row, with two or more results per pixel, holds the
// input back, and the extra row-end result of other rows is absorbed by an
// 8-entry result queue. An input passes the registered line store read into
// stage 1, then the channel lanes into the queue. image_width and
// image_height take effect at the next pixel; a position beyond the new size
// wraps to the next row or to row 0. Line stores hold no reset value and need no clearing pass.
module rgb_sharpen_3x3 #(
  parameter int MAX_LINE_PIXELS = rgbs_pkg::MAX_LINE_PIXELS_DEF,
  parameter int MAX_ROWS        = rgbs_pkg::MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rgbs_pix_if.sink   in_if,
  rgbs_res_if.source out_if,
  rgbs_cfg_if.sink   cfg_if
);

  localparam int CW = $clog2(MAX_LINE_PIXELS);      // column counter
  localparam int RW = $clog2(MAX_ROWS);             // row counter
  localparam int WW = $clog2(MAX_LINE_PIXELS + 1);  // width in use
  localparam int HW = $clog2(MAX_ROWS + 1);         // height in use
  localparam int PXW = $bits(rgbs_pkg::pixel_t);

  // config registers
  logic [rgbs_pkg::IMG_W_W-1:0] width_r;
  logic [rgbs_pkg::IMG_H_W-1:0] height_r;
  logic [WW-1:0]                w_used, w_m1;
  logic [HW-1:0]                h_used, h_m1;

  // position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] c_cur;
  logic [RW:0]   r_inc;
  logic [RW-1:0] r_cur;
  logic [CW:0]   c_next;
  logic [RW:0]   r_next;

  // stage 1: line store read in flight
  logic                 s1_valid_r;
  logic                 s1_fire;
  logic                 in_fire;
  rgbs_pkg::pixel_t     in_px;
  rgbs_pkg::pixel_t     s1_px_r;
  logic [CW-1:0]        s1_c_r;
  logic [RW-1:0]        s1_r_r;
  logic                 s1_e_center_r, s1_e_rowend_r, s1_e_lastrow_r, s1_int_r;
  rgbs_pkg::pixel_t     top_px, mid_px;

  // 3x3 window, index column*3+row, newest column at 6..8
  rgbs_pkg::pixel_t win_r [rgbs_pkg::WIN_N];
  rgbs_pkg::pixel_t win_nxt [rgbs_pkg::WIN_N];

  logic [rgbs_pkg::NUM_CH-1:0][rgbs_pkg::WIN_N-1:0][rgbs_pkg::PIX_W-1:0] lane_win;
  rgbs_pkg::pixel_t  sharp_px;
  rgbs_pkg::bundle_t bnd;
  logic              bnd_ready;

  logic [CW+rgbs_pkg::COL_OUT_W-1:0] c_ext;
  logic [RW+rgbs_pkg::ROW_OUT_W-1:0] r_ext;

  // ---------------- configuration ----------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rgbs_pkg::IMG_W_RST;
      height_r <= rgbs_pkg::IMG_H_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        rgbs_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_if.data[rgbs_pkg::IMG_W_W-1:0];
        rgbs_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_if.data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // sizes clamped to what the stores and counters hold
  always_comb begin
    if (width_r < rgbs_pkg::IMG_W_W'(3)) begin
      w_used = WW'(3);
    end else if (32'(width_r) > MAX_LINE_PIXELS) begin
      w_used = WW'(MAX_LINE_PIXELS);
    end else begin
      w_used = WW'(width_r);
    end
    if (height_r < rgbs_pkg::IMG_H_W'(3)) begin
      h_used = HW'(3);
    end else if (32'(height_r) > MAX_ROWS) begin
      h_used = HW'(MAX_ROWS);
    end else begin
      h_used = HW'(height_r);
    end
  end

  assign w_m1 = w_used - WW'(1);
  assign h_m1 = h_used - HW'(1);

  // ---------------- position ----------------
  // wrap first, in case the size shrank under the current position
  always_comb begin
    if (WW'(col_r) >= w_used) begin
      c_cur = '0;
      r_inc = {1'b0, row_r} + (RW+1)'(1);
    end else begin
      c_cur = col_r;
      r_inc = {1'b0, row_r};
    end
    r_cur = (r_inc >= (RW+1)'(h_used)) ? '0 : r_inc[RW-1:0];

    c_next = {1'b0, c_cur} + (CW+1)'(1);
    r_next = {1'b0, r_cur} + (RW+1)'(1);
    if (c_next >= (CW+1)'(w_used)) begin
      col_nxt = '0;
      row_nxt = (r_next >= (RW+1)'(h_used)) ? '0 : r_next[RW-1:0];
    end else begin
      col_nxt = c_next[CW-1:0];
      row_nxt = r_cur;
    end
  end

  // ---------------- handshake ----------------
  assign s1_fire     = s1_valid_r && bnd_ready;
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_px       = {in_if.red_in, in_if.green_in, in_if.blue_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage 1 payload and which results this pixel causes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r        <= in_px;
      s1_c_r         <= c_cur;
      s1_r_r         <= r_cur;
      s1_e_center_r  <= (r_cur != '0) && (c_cur != '0);
      s1_e_rowend_r  <= (r_cur != '0) && (WW'(c_cur) == w_m1);
      s1_e_lastrow_r <= HW'(r_cur) == h_m1;
      s1_int_r       <= (c_cur >= CW'(2)) && (r_cur >= RW'(2));
    end
  end

  // ---------------- line stores ----------------
  // read at acceptance, written back when the pixel leaves stage 1
  rgbs_ram #(.WIDTH(PXW), .DEPTH(MAX_LINE_PIXELS)) u_line_prev (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_c_r),
    .wdata (s1_px_r),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (mid_px)
  );

  rgbs_ram #(.WIDTH(PXW), .DEPTH(MAX_LINE_PIXELS)) u_line_older (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_c_r),
    .wdata (mid_px),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (top_px)
  );

  // ---------------- window ----------------
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = win_r[i+3];
    end
    win_nxt[6] = top_px;
    win_nxt[7] = mid_px;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rgbs_pkg::WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < rgbs_pkg::WIN_N; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // ---------------- channel lanes ----------------
  always_comb begin
    for (int ch = 0; ch < rgbs_pkg::NUM_CH; ch++) begin
      for (int i = 0; i < rgbs_pkg::WIN_N; i++) begin
        lane_win[ch][i] = win_nxt[i][ch];
      end
    end
  end

  for (genvar ch = 0; ch < rgbs_pkg::NUM_CH; ch++) begin : g_lane
    rgbs_lane u_lane (
      .win   (lane_win[ch]),
      .sharp (sharp_px[ch])
    );
  end

  // ---------------- merge ----------------
  assign c_ext = {{rgbs_pkg::COL_OUT_W{1'b0}}, s1_c_r};
  assign r_ext = {{rgbs_pkg::ROW_OUT_W{1'b0}}, s1_r_r};

  always_comb begin
    bnd.e_center     = s1_e_center_r;
    bnd.e_rowend     = s1_e_rowend_r;
    bnd.e_lastrow    = s1_e_lastrow_r;
    bnd.interior     = s1_int_r;
    bnd.col          = c_ext[rgbs_pkg::COL_OUT_W-1:0];
    bnd.row          = r_ext[rgbs_pkg::ROW_OUT_W-1:0];
    bnd.sharp        = sharp_px;
    bnd.pass_center  = win_nxt[rgbs_pkg::WIN_CTR];
    bnd.pass_rowend  = win_nxt[7];
    bnd.pass_lastrow = s1_px_r;
  end

  rgbs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_valid (s1_valid_r),
    .bnd       (bnd),
    .bnd_ready (bnd_ready),
    .out_if    (out_if)
  );

endmodule
